// ----- sv/lrx_pkg.sv -----
// ----------------------------------------------------------------------------
// lrx_pkg: shared definitions for the left-to-right expression evaluator
// Operator codes, character codes, divider sizing and the controller to
// datapath command and status bundles.
// ----------------------------------------------------------------------------
package lrx_pkg;

  // Pending operator encoding
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // ASCII codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Controller -> datapath
  typedef struct packed {
    logic accept;      // request taken this cycle
    logic apply;       // apply pending operator (starts divider if needed)
    logic div_step;    // one restoring-division iteration
    logic div_fix;     // sign-correct quotient into running result
    logic emit;        // load output register and re-arm
  } lrx_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic trigger;     // incoming request is an operator or last character
    logic last;        // captured request was the last character
    logic div_nz;      // pending operator is divide with non-zero operand
    logic out_free;    // output register can take a result this cycle
  } lrx_sts_t;

endpackage

// ----- sv/lrx_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrx_ctrl: sequencing state machine
// Takes requests in idle, steps the datapath through apply, the iterative
// divide and the result hand-off.
// ----------------------------------------------------------------------------
module lrx_ctrl import lrx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  lrx_sts_t sts,
  output lrx_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APPLY = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_DFIX  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_CNT_W-1:0] div_cnt_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.trigger) state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (sts.div_nz) begin
          state_next   = S_DIV;
          div_cnt_next = '0;
        end else if (sts.last) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) state_next = S_DFIX;
      end
      S_DFIX: begin
        cmd.div_fix = 1'b1;
        state_next  = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("emit while output register busy");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && sts.div_nz) |=> (state == S_DIV && div_cnt == '0))
    else $error("divider not started after apply");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == DIV_LAST) |=> (state == S_DFIX))
    else $error("divider did not finish after full iteration count");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && sts.out_free) |=> (state == S_IDLE))
    else $error("controller did not return to idle after emit");

endmodule

// ----- sv/lrx_dp.sv -----
// ----------------------------------------------------------------------------
// lrx_dp: evaluator datapath
// Operand accumulator, running result, pending operator, restoring
// divider on magnitudes and the output register.
// ----------------------------------------------------------------------------
module lrx_dp import lrx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               character,
  input  logic                     is_last,
  input  lrx_cmd_t                 cmd,
  output lrx_sts_t                 sts,
  output logic signed [DATA_W-1:0] value,
  output logic                     divide_by_zero,
  output logic                     out_valid,
  input  logic                     out_stall
);

  logic [DATA_W-1:0] running_result;
  logic [DATA_W-1:0] acc;
  logic [1:0]        pending_op;
  logic              zdiv_seen;

  // captured request
  logic              last_q;
  logic              has_op_q;
  logic [1:0]        op_q;

  // divider
  logic [DATA_W-1:0] div_rem;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] div_den;
  logic              div_neg;

  // decode
  logic              in_digit;
  logic              in_is_op;
  logic [1:0]        in_op;
  logic [DATA_W-1:0] acc_next;

  logic [DATA_W-1:0] num_mag;
  logic [DATA_W-1:0] den_mag;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  assign in_digit = (character >= CH_ZERO) && (character <= CH_NINE);

  always_comb begin
    in_is_op = 1'b1;
    in_op    = OP_ADD;
    case (character)
      CH_PLUS:  in_op = OP_ADD;
      CH_MINUS: in_op = OP_SUB;
      CH_STAR:  in_op = OP_MUL;
      CH_SLASH: in_op = OP_DIV;
      default:  in_is_op = 1'b0;
    endcase
  end

  // acc * 10 + digit as shift-add
  assign acc_next = {acc[DATA_W-4:0], 3'b000} + {acc[DATA_W-2:0], 1'b0}
                  + {{(DATA_W-4){1'b0}}, 4'(character - CH_ZERO)};

  assign num_mag = running_result[DATA_W-1] ? (~running_result + 1'b1) : running_result;
  assign den_mag = acc[DATA_W-1] ? (~acc + 1'b1) : acc;
  assign trial   = {div_rem, div_quo[DATA_W-1]};
  assign diff    = trial - {1'b0, div_den};

  assign sts.trigger  = in_is_op || is_last;
  assign sts.last     = last_q;
  assign sts.div_nz   = (pending_op == OP_DIV) && (acc != '0);
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_result <= '0;
      acc            <= '0;
      pending_op     <= OP_ADD;
      zdiv_seen      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cmd.accept) begin
        if (in_digit) acc <= acc_next;
        last_q   <= is_last;
        has_op_q <= in_is_op;
        op_q     <= in_op;
      end

      if (cmd.apply) begin
        case (pending_op)
          OP_ADD: running_result <= running_result + acc;
          OP_SUB: running_result <= running_result - acc;
          OP_MUL: running_result <= running_result * acc;
          default: begin
            if (acc == '0) begin
              zdiv_seen <= 1'b1;
            end else begin
              div_rem <= '0;
              div_quo <= num_mag;
              div_den <= den_mag;
              div_neg <= running_result[DATA_W-1] ^ acc[DATA_W-1];
            end
          end
        endcase
        acc <= '0;
        if (has_op_q) pending_op <= op_q;
      end

      if (cmd.div_step) begin
        if (!diff[DATA_W]) begin
          div_rem <= diff[DATA_W-1:0];
          div_quo <= {div_quo[DATA_W-2:0], 1'b1};
        end else begin
          div_rem <= trial[DATA_W-1:0];
          div_quo <= {div_quo[DATA_W-2:0], 1'b0};
        end
      end

      if (cmd.div_fix) begin
        running_result <= div_neg ? (~div_quo + 1'b1) : div_quo;
      end

      if (cmd.emit) begin
        value          <= running_result;
        divide_by_zero <= zdiv_seen;
        out_valid      <= 1'b1;
        running_result <= '0;
        acc            <= '0;
        pending_op     <= OP_ADD;
        zdiv_seen      <= 1'b0;
      end
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (out_valid && pending_op == OP_ADD && acc == '0))
    else $error("emit did not publish result and re-arm");

  a_zdiv_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !zdiv_seen)
    else $error("divide-by-zero flag survived re-arm");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(value) && $stable(divide_by_zero)))
    else $error("stalled result changed or dropped");

endmodule

// ----- sv/left_to_right_expression_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// left_to_right_expression_evaluator_top: streaming integer expression unit
// Evaluates +, -, *, / expressions one ASCII character per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: character / is_last with in_valid, in_stall. Digits build
//   a decimal operand; operators apply the pending one strictly left to right
//   (no precedence). Other characters are ignored. is_last closes the
//   expression and produces one result on the output channel.
//   Output channel: value / divide_by_zero with out_valid, out_stall.
//   divide_by_zero is sticky across one expression; a divide by zero leaves
//   the running result unchanged.
// Controller sequence per request:
//   digit or ignored character: accept
//   operator or last with +, - or * pending: accept, apply
//   divide pending, non-zero divisor: accept, apply, one iteration of
//     the restoring divider per quotient bit, sign fix
//   last character: then the output register load, once it is free.
// Reset clears all evaluation state and drops out_valid. A stalled result
// holds in the output register; new requests keep flowing until the next
// last character, which waits until the register frees up.
// ----------------------------------------------------------------------------
module left_to_right_expression_evaluator_top import lrx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               character,
  input  logic                     is_last,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic signed [DATA_W-1:0] value,
  output logic                     divide_by_zero,
  output logic                     out_valid,
  input  logic                     out_stall
);

  lrx_cmd_t cmd;
  lrx_sts_t sts;

  // sequencing
  lrx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and output register
  lrx_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .character      (character),
    .is_last        (is_last),
    .cmd            (cmd),
    .sts            (sts),
    .value          (value),
    .divide_by_zero (divide_by_zero),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the left-to-right expression evaluator
// Feeds ASCII expressions one character per request and checks every result
// (value and divide-by-zero flag) against a cycle-free evaluator kept here.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lrx_pkg::*;

  localparam int CYCLE_LIMIT  = 500000; // far above the slowest legal run
  localparam int SETTLE_TICKS = 40;     // a divide plus the output load

  // One expected result of a closed expression
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     dz;
  } eval_result_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic [7:0]               character;
  logic                     is_last;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] value;
  logic                     divide_by_zero;
  logic                     out_valid;
  logic                     out_stall;

  // Evaluator state, mirrors what the block holds between requests
  logic [DATA_W-1:0] run_value   = '0;
  logic [DATA_W-1:0] operand     = '0;
  logic [1:0]        pending_op  = OP_ADD;
  logic              saw_div0    = 1'b0;

  eval_result_t results_due[$];   // results still owed by the block

  bit sender_gaps  = 1'b0;        // random idle bursts on the request side
  bit stall_bursts = 1'b0;        // random stall bursts on the result side

  int errors          = 0;
  int chars_sent      = 0;
  int results_checked = 0;
  int div0_results    = 0;
  int cycle_count     = 0;

  left_to_right_expression_evaluator_top dut (
    .clk            (clk),
    .rst            (rst),
    .character      (character),
    .is_last        (is_last),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .value          (value),
    .divide_by_zero (divide_by_zero),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed",
               cycle_count, results_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Evaluator
  // --------------------------------------------------------------------------

  // Signed divide, truncating toward zero; the most negative value divided
  // by minus one comes back as itself.
  function automatic logic [DATA_W-1:0] quotient_rtz(input logic [DATA_W-1:0] num,
                                                     input logic [DATA_W-1:0] den);
    logic [DATA_W-1:0] mag_n, mag_d, q;
    mag_n = num[DATA_W-1] ? -num : num;
    mag_d = den[DATA_W-1] ? -den : den;
    q     = mag_n / mag_d;
    return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
  endfunction

  // Advance the evaluator by one accepted request; a closing request queues
  // the result the block owes and re-arms the evaluator.
  function automatic void eval_char(input logic [7:0] c, input logic l);
    logic [1:0]   op;
    logic         is_op;
    eval_result_t r;
    is_op = 1'b1;
    op    = OP_ADD;
    if (c >= CH_ZERO && c <= CH_NINE)
      operand = operand * 32'd10 + DATA_W'(c - CH_ZERO);
    case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  is_op = 1'b0;
    endcase
    if (is_op || l) begin
      case (pending_op)
        OP_ADD: run_value = run_value + operand;
        OP_SUB: run_value = run_value - operand;
        OP_MUL: run_value = run_value * operand;
        default: begin
          // divide by zero keeps the running value and flags the expression
          if (operand != '0) run_value = quotient_rtz(run_value, operand);
          else saw_div0 = 1'b1;
        end
      endcase
      operand = '0;
      if (is_op) pending_op = op;
    end
    if (l) begin
      r.value = run_value;
      r.dz    = saw_div0;
      results_due.push_back(r);
      run_value  = '0;
      operand    = '0;
      pending_op = OP_ADD;
      saw_div0   = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, and the checker
  // --------------------------------------------------------------------------

  // A burst in progress ends early once bursts are switched off
  initial begin : result_stalls
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_bursts && $urandom_range(0, 11) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) if (stall_bursts) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input longint expd, input longint got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, expd, got);
    errors++;
  endtask

  // Every result taken at a rising edge is matched against the oldest one owed
  always @(posedge clk) begin : check_results
    eval_result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result, value", 0, value);
      end else begin
        due = results_due.pop_front();
        if (value !== due.value) report_mismatch("value", due.value, value);
        if (divide_by_zero !== due.dz)
          report_mismatch("divide_by_zero", due.dz, divide_by_zero);
        results_checked++;
        if (due.dz) div0_results++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // One request: drive at a falling edge, hold until taken at a rising edge.
  // Returns right after the accepting edge, so valid stays up for a
  // back-to-back follower.
  task automatic send_char(input logic [7:0] c, input logic l);
    int gap;
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    character <= c;
    is_last   <= l;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    eval_char(c, l);
    chars_sent++;
  endtask

  // Whole string; the closing flag rides on its final character
  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], close && (i == s.len() - 1));
  endtask

  // Drop valid and hold off until the block has handed over every result
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] op_char();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Any byte that is neither a digit nor an operator
  function automatic logic [7:0] ignored_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_STAR || c == CH_SLASH);
    return c;
  endfunction

  // Mostly short operands; now and then zero, the 32-bit edges, or a digit
  // string long enough to wrap the accumulator.
  function automatic string operand_text();
    case ($urandom_range(0, 15))
      0:       return "0";
      1:       return "4294967295";
      2:       return "2147483648";
      3:       return $sformatf("%0d", $urandom);
      4:       return $sformatf("%0d", {$urandom, $urandom});
      5, 6:    return $sformatf("%0d", $urandom_range(0, 9));
      default: return $sformatf("%0d", $urandom_range(0, 999));
    endcase
  endfunction

  // One well-formed expression with random content, sometimes with a
  // leading or trailing operator or a stray character
  task automatic send_random_expr();
    logic [7:0] text[$];
    string      num;
    int         terms;
    terms = $urandom_range(1, 5);
    if ($urandom_range(0, 7) == 0) text.push_back(op_char());
    for (int t = 0; t < terms; t++) begin
      if (t > 0) text.push_back(op_char());
      num = operand_text();
      for (int i = 0; i < num.len(); i++) text.push_back(num[i]);
      if ($urandom_range(0, 11) == 0) text.push_back(ignored_char());
    end
    case ($urandom_range(0, 5))
      0:       text.push_back(op_char());
      1:       text.push_back(ignored_char());
      default: ;
    endcase
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
    // now and then the sender holds off until the pipeline is empty
    if ($urandom_range(0, 19) == 0) wait_results_done();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked expressions covering -, * and / and the corner cases
  task automatic test_directed();
    send_text("9", 1'b1);                 // single digit that closes at once
    send_text("5/0*", 1'b1);              // divide by zero, trailing operator
    // leading minus, three of the operators, 0xFF ignored, NUL closes; flag must
    // be clear again after the previous expression
    send_text("-7*", 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("3/2", 1'b0);
    send_char(8'h00, 1'b1);
    // most negative value over minus one (operand is all ones)
    send_text("2147483648/4294967295", 1'b1);
    wait_results_done();
  endtask

  // Bulk of the run: random expressions with idle and stall bursts
  task automatic test_random_expressions(input int n_chars);
    int stop_at;
    stop_at      = chars_sent + n_chars;
    sender_gaps  = 1'b1;
    stall_bursts = 1'b1;
    while (chars_sent < stop_at) send_random_expr();
    wait_results_done();
  endtask

  // Broken input: raw bytes with the closing flag set at random
  task automatic test_noise(input int n_chars);
    logic [7:0] c;
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(0, 1) == 0) c = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 1) == 0) c = op_char();
      else c = CH_ZERO + 8'($urandom_range(0, 9));
      send_char(c, $urandom_range(0, 7) == 0);
    end
    send_char(ignored_char(), 1'b1);      // close whatever was left open
    wait_results_done();
  endtask

  // Final stretch at full rate on both sides
  task automatic test_full_rate(input int n_chars);
    int stop_at;
    stop_at      = chars_sent + n_chars;
    sender_gaps  = 1'b0;
    stall_bursts = 1'b0;
    while (chars_sent < stop_at) send_random_expr();
    wait_results_done();
  endtask

  initial begin
    rst       = 1'b1;
    character = '0;
    is_last   = 1'b0;
    in_valid  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_expressions(280);
    test_noise(60);
    test_full_rate(60);

    // let any late output show up as an unexpected result
    repeat (SETTLE_TICKS) @(negedge clk);
    if (results_due.size() != 0)
      report_mismatch("results never delivered, count", 0, results_due.size());

    $display("Sent %0d characters (directed, random, noise, full rate); checked %0d results,",
             chars_sent, results_checked);
    $display("%0d of them with a skipped divide by zero.", div0_results);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
